FILE: rtl/core/dtp_pkg.sv
// ----------------------------------------------------------------------------
// Decimal integer text parser package
// Shared widths, character codes, parse phases, the parser state record and character tests.
// ----------------------------------------------------------------------------
`default_nettype none

package dtp_pkg;

    localparam int VALUE_WIDTH = 64;   // accumulator width, 8 to 64
    localparam int CH_WIDTH    = 8;
    localparam int OUT_WIDTH   = 64;

    localparam logic [CH_WIDTH-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_WIDTH-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_WIDTH-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_WIDTH-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_WIDTH-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_WIDTH-1:0] CH_VT    = 8'h0B;
    localparam logic [CH_WIDTH-1:0] CH_FF    = 8'h0C;
    localparam logic [CH_WIDTH-1:0] CH_CR    = 8'h0D;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGN,
        PH_DIGITS,
        PH_TRAIL,
        PH_ERROR
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic [VALUE_WIDTH-1:0] acc;
        logic                   negative;
    } parse_state_t;

    localparam parse_state_t PARSE_STATE_RESET = '{
        phase:    PH_START,
        acc:      '0,
        negative: 1'b0
    };

    function automatic logic is_space(input logic [CH_WIDTH-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic is_digit(input logic [CH_WIDTH-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/decimal_integer_text_parser.sv
// ----------------------------------------------------------------------------
// Decimal integer text parser
// Parses a zero-terminated byte string into a signed integer with error flag.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload        Items
//  input    in_valid / in_ready    ch[7:0]        one string byte, 0 ends it
//  output   out_valid / out_ready  value, error   one per terminator byte
//
//  One byte is taken every cycle unless a terminator waits on a stalled result;
//  the parser state register closes its loop through a shift-add multiply by ten.
//  A result appears in the output register the cycle after its terminator.
//  While a result is stalled, ordinary bytes still flow; only a terminator
//  waits for the output register to free up.
//  Reset returns the parser to its start state with a zero accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_integer_text_parser (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [dtp_pkg::CH_WIDTH-1:0]        ch,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [dtp_pkg::OUT_WIDTH-1:0]     value,
    output logic                                     error
);
    import dtp_pkg::*;

    parse_state_t                  state_reg;
    parse_state_t                  state_next;
    logic signed [OUT_WIDTH-1:0]   res_value;
    logic                          res_error;
    logic                          out_valid_reg;
    logic signed [OUT_WIDTH-1:0]   value_reg;
    logic                          error_reg;
    logic                          in_accept;
    logic                          term_accept;

    dtp_step u_step (
        .ch         (ch),
        .state_cur  (state_reg),
        .state_next (state_next),
        .res_value  (res_value),
        .res_error  (res_error)
    );

    assign in_ready    = !out_valid_reg || out_ready || (ch != CH_NUL);
    assign in_accept   = in_valid && in_ready;
    assign term_accept = in_accept && (ch == CH_NUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PARSE_STATE_RESET;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            error_reg     <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                state_reg <= state_next;
            end
            if (term_accept)
            begin
                out_valid_reg <= 1'b1;
                value_reg     <= res_value;
                error_reg     <= res_error;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign error     = error_reg;

    // A terminator leaves the parser in its start state with nothing kept.
    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        term_accept |=> (state_reg == PARSE_STATE_RESET))
        else $error("parser state not cleared after terminator");

    // Every accepted terminator shows up as a waiting result.
    a_term_result: assert property (@(posedge clk) disable iff (!rst_n)
        term_accept |=> out_valid)
        else $error("terminator produced no result");

    // A flagged string never reports a nonzero value.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error) |-> (value == '0))
        else $error("error result carries a nonzero value");

    // An ordinary byte, taken while no result waits, never raises a result.
    a_byte_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (ch != CH_NUL) && !out_valid) |=> !out_valid)
        else $error("result appeared without a terminator");

endmodule

`default_nettype wire

FILE: rtl/core/dtp_step.sv
// ----------------------------------------------------------------------------
// Parser step logic
// Next parser state for one byte, and the finished result on a terminator.
// ----------------------------------------------------------------------------
`default_nettype none

module dtp_step (
    input  wire logic [dtp_pkg::CH_WIDTH-1:0]  ch,
    input  wire dtp_pkg::parse_state_t         state_cur,
    output dtp_pkg::parse_state_t              state_next,
    output logic signed [dtp_pkg::OUT_WIDTH-1:0] res_value,
    output logic                               res_error
);
    import dtp_pkg::*;

    logic                          ch_space;
    logic                          ch_digit;
    logic [3:0]                    digit_val;
    logic [VALUE_WIDTH-1:0]        acc_step;
    parse_state_t                  digit_state;
    logic [VALUE_WIDTH-1:0]        mag;
    logic signed [VALUE_WIDTH-1:0] signed_val;

    assign ch_space  = is_space(ch);
    assign ch_digit  = is_digit(ch);
    assign digit_val = 4'(ch - CH_ZERO);

    // Multiply by ten as two shifts and an add; wraps at the accumulator width.
    assign acc_step = (state_cur.acc << 3) + (state_cur.acc << 1)
                    + VALUE_WIDTH'(digit_val);

    // Handling of a byte where a digit may stand.
    always_comb
    begin
        digit_state = state_cur;
        if (ch_digit)
        begin
            digit_state.acc   = acc_step;
            digit_state.phase = PH_DIGITS;
        end
        else if (ch_space)
        begin
            digit_state.phase = PH_TRAIL;
        end
        else
        begin
            digit_state.phase = PH_ERROR;
        end
    end

    always_comb
    begin
        state_next = state_cur;
        if (ch == CH_NUL)
        begin
            state_next = PARSE_STATE_RESET;
        end
        else
        begin
            unique case (state_cur.phase)
                PH_START:
                begin
                    if (ch_space)
                    begin
                        state_next = state_cur;
                    end
                    else if (ch == CH_MINUS)
                    begin
                        state_next.negative = 1'b1;
                        state_next.phase    = PH_SIGN;
                    end
                    else
                    begin
                        state_next = digit_state;
                    end
                end
                PH_SIGN, PH_DIGITS:
                begin
                    state_next = digit_state;
                end
                PH_TRAIL:
                begin
                    if (!ch_space)
                    begin
                        state_next.phase = PH_ERROR;
                    end
                end
                default:
                begin
                    state_next.phase = PH_ERROR;
                end
            endcase
        end
    end

    // A sign followed only by whitespace still counts as a valid zero.
    assign res_error  = !((state_cur.phase == PH_DIGITS) || (state_cur.phase == PH_TRAIL));
    assign mag        = state_cur.acc;
    assign signed_val = state_cur.negative ? signed'(-mag) : signed'(mag);
    assign res_value  = res_error ? '0 : OUT_WIDTH'(signed_val);

endmodule

`default_nettype wire
